// ===== src/gcd_pkg.sv =====
// shared constants and types for the gcd unit
`timescale 1ns / 1ps
`default_nettype none

package gcd_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int SHIFT_W     = $clog2(DATA_WIDTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [DATA_WIDTH-1:0] mag_t;

  typedef struct packed {
    mag_t a;
    mag_t b;
  } operands_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } core_state_t;

endpackage

`default_nettype wire

// ===== src/gcd_front.sv =====
// front end: takes operands and turns them into magnitudes for the queue
`timescale 1ns / 1ps
`default_nettype none

module gcd_front
  import gcd_pkg::*;
(
  input  wire logic signed [DATA_WIDTH-1:0] first_value,
  input  wire logic signed [DATA_WIDTH-1:0] second_value,
  output operands_t                         item
);

  mag_t raw_a;
  mag_t raw_b;

  assign raw_a = $unsigned(first_value);
  assign raw_b = $unsigned(second_value);

  // most negative value wraps to 2^(w-1), which the unsigned field holds
  always_comb begin
    item.a = raw_a[DATA_WIDTH-1] ? (~raw_a + mag_t'(1)) : raw_a;
    item.b = raw_b[DATA_WIDTH-1] ? (~raw_b + mag_t'(1)) : raw_b;
  end

endmodule

`default_nettype wire

// ===== src/gcd_queue.sv =====
// short queue of operand pairs between the front end and the engine
`timescale 1ns / 1ps
`default_nettype none

module gcd_queue
  import gcd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_en,
  input  wire operands_t wr_item,
  output logic           full,
  input  wire logic      rd_en,
  output operands_t      rd_item,
  output logic           empty
);

  operands_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QCNT_W-1:0]     count;
  logic                  do_wr;
  logic                  do_rd;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/gcd_core.sv =====
// back end: binary gcd engine with a result register
`timescale 1ns / 1ps
`default_nettype none

module gcd_core
  import gcd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire operands_t q_item,
  input  wire logic      q_empty,
  output logic           q_pop,
  output logic           empty,
  input  wire logic      pop,
  output logic [DATA_WIDTH-1:0] divisor
);

  core_state_t           state;
  core_state_t           state_next;
  mag_t                  a;
  mag_t                  a_next;
  mag_t                  b;
  mag_t                  b_next;
  logic [SHIFT_W-1:0]    k;
  logic [SHIFT_W-1:0]    k_next;
  mag_t                  result;
  mag_t                  result_next;
  mag_t                  diff_ab;
  mag_t                  diff_ba;

  assign diff_ab = a - b;
  assign diff_ba = b - a;
  assign empty   = (state != ST_DONE);
  assign divisor = result;

  always_comb begin
    state_next  = state;
    a_next      = a;
    b_next      = b;
    k_next      = k;
    result_next = result;
    q_pop       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          a_next     = q_item.a;
          b_next     = q_item.b;
          k_next     = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (a == '0) begin
          result_next = b << k;
          state_next  = ST_DONE;
        end else if (b == '0) begin
          result_next = a << k;
          state_next  = ST_DONE;
        end else if (!a[0] && !b[0]) begin
          // common factor of two, put back at the end
          a_next = a >> 1;
          b_next = b >> 1;
          k_next = k + SHIFT_W'(1);
        end else if (!a[0]) begin
          a_next = a >> 1;
        end else if (!b[0]) begin
          b_next = b >> 1;
        end else if (a >= b) begin
          // both odd, so the difference is even
          a_next = diff_ab >> 1;
        end else begin
          b_next = diff_ba >> 1;
        end
      end
      ST_DONE: begin
        if (pop) begin
          if (!q_empty) begin
            q_pop      = 1'b1;
            a_next     = q_item.a;
            b_next     = q_item.b;
            k_next     = '0;
            state_next = ST_RUN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    a      <= a_next;
    b      <= b_next;
    k      <= k_next;
    result <= result_next;
  end

endmodule

`default_nettype wire

// ===== src/gcd_unit.sv =====
// gcd unit top level: front end, operand queue and gcd engine
//
// Input side looks like a queue: an item (first_value, second_value) is
// taken at a clock edge with push high and full low. The front end turns
// both operands into magnitudes and writes them to a two-entry queue.
// Result side also looks like a queue: while empty is low, divisor holds
// the gcd of the oldest item; it is taken at an edge with pop high.
// From the accepting edge: the engine is loaded from the queue, runs its
// steps (binary gcd: halving or subtract-and-halve) until one operand is
// zero, then writes the result shifted back by the common factor of two.
// Throughput is one item per engine run; the engine loads the next queued
// item in the cycle its result is popped.
// When the receiver stalls the result stays put, the engine waits and the
// queue keeps taking items until it holds two, then full goes high.
// Synchronous reset empties the queue and the result slot.
`timescale 1ns / 1ps
`default_nettype none

module gcd_unit
  import gcd_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic signed [DATA_WIDTH-1:0] first_value,
  input  wire logic signed [DATA_WIDTH-1:0] second_value,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [DATA_WIDTH-1:0]             divisor
);

  operands_t front_item;
  operands_t q_item;
  logic      q_empty;
  logic      q_pop;

  gcd_front u_front (
    .first_value  (first_value),
    .second_value (second_value),
    .item         (front_item)
  );

  gcd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_item (front_item),
    .full    (full),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  gcd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .divisor (divisor)
  );

endmodule

`default_nettype wire
